// File: sv/flight_mode_supervisor_defines.svh
// ----------------------------------------------------------------------------
// Flight mode supervisor assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_MODE_SUPERVISOR_DEFINES_SVH
`define FLIGHT_MODE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define FMS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define FMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must follow a reset cycle
`define FMS_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// File: sv/fms_pkg.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor package
// Field widths, request and register codes, phase encoding and shared types.
// ----------------------------------------------------------------------------
package fms_pkg;

   // Field widths
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned ALT_W      = 18;
   localparam int unsigned VEL_IN_W   = 16;
   localparam int unsigned DT_W       = 10;
   localparam int unsigned TIMER_W    = 16;
   localparam int unsigned CT_W       = 14;
   localparam int unsigned CR_W       = 10;
   localparam int unsigned DR_W       = 11;
   localparam int unsigned TD_W       = 9;
   localparam int unsigned VG_W       = 11;
   localparam int unsigned STATE_W    = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 40;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ARM     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DISARM  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TAKEOFF = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LAND    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_HOVER   = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CLIMB_TARGET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ASCENT_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_TIME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SINK_SPEED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOUCHDOWN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DISARM_DELAY = 3'd5;

   // Reported state codes
   localparam logic [STATE_W-1:0] ST_CODE_DISARMED = 3'd0;
   localparam logic [STATE_W-1:0] ST_CODE_ARMED    = 3'd1;
   localparam logic [STATE_W-1:0] ST_CODE_TAKEOFF  = 3'd2;
   localparam logic [STATE_W-1:0] ST_CODE_HOVER    = 3'd3;
   localparam logic [STATE_W-1:0] ST_CODE_LAND     = 3'd4;
   localparam logic [STATE_W-1:0] ST_CODE_LANDED   = 3'd5;

   // Register limits and reset values
   localparam logic [CT_W-1:0]        CT_MIN    = 14'd500;
   localparam logic [CT_W-1:0]        CT_MAX    = 14'd15000;
   localparam logic [CT_W-1:0]        CT_RESET  = 14'd2000;
   localparam logic [CR_W-1:0]        CR_MIN    = 10'd200;
   localparam logic [CR_W-1:0]        CR_MAX    = 10'd1000;
   localparam logic [CR_W-1:0]        CR_RESET  = 10'd500;
   localparam logic [TIMER_W-1:0]     TIME_MAX  = 16'd60000;
   localparam logic [TIMER_W-1:0]     TIME_RESET = 16'd2000;
   localparam logic signed [DR_W-1:0] DR_MIN    = -11'sd1000;
   localparam logic signed [DR_W-1:0] DR_MAX    = -11'sd100;
   localparam logic signed [DR_W-1:0] DR_RESET  = -11'sd300;
   localparam logic [TD_W-1:0]        TD_MIN    = 9'd100;
   localparam logic [TD_W-1:0]        TD_MAX    = 9'd500;
   localparam logic [TD_W-1:0]        TD_RESET  = 9'd300;

   // Window limits used on a tick
   localparam logic signed [ALT_W:0]      SETTLE_WINDOW = 19'sd200;
   localparam logic [TD_W:0]              LOW_MARGIN    = 10'd100;
   localparam logic signed [VEL_IN_W-1:0] SLOW_WINDOW   = 16'sd200;

   // Flight phase, one-hot
   typedef enum logic [5:0] {
      PH_DISARMED = 6'b000001,
      PH_ARMED    = 6'b000010,
      PH_TAKEOFF  = 6'b000100,
      PH_HOVER    = 6'b001000,
      PH_LAND     = 6'b010000,
      PH_LANDED   = 6'b100000
   } phase_type;

   // Configuration registers as seen by the core
   typedef struct packed {
      logic [CT_W-1:0]        climb_target;
      logic [CR_W-1:0]        ascent_speed;
      logic [TIMER_W-1:0]     settle_time;
      logic signed [DR_W-1:0] sink_speed;
      logic [TD_W-1:0]        touchdown_alt;
      logic [TIMER_W-1:0]     disarm_delay;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      climb_target:  CT_RESET,
      ascent_speed:  CR_RESET,
      settle_time:   TIME_RESET,
      sink_speed:    DR_RESET,
      touchdown_alt: TD_RESET,
      disarm_delay:  TIME_RESET
   };

   // Result item, accepted in the lowest bit
   typedef struct packed {
      logic                   hold_active;
      logic signed [VG_W-1:0] velocity_goal;
      logic signed [ALT_W-1:0] altitude_goal;
      logic [STATE_W-1:0]     flight_state;
      logic                   accepted;
   } rsp_type;

   localparam int unsigned RSP_W = $bits(rsp_type);

   // Map the one-hot phase to its reported code
   function automatic logic [STATE_W-1:0] phase_code(input phase_type p);
      logic [STATE_W-1:0] c;
      unique case (p)
         PH_DISARMED: c = ST_CODE_DISARMED;
         PH_ARMED:    c = ST_CODE_ARMED;
         PH_TAKEOFF:  c = ST_CODE_TAKEOFF;
         PH_HOVER:    c = ST_CODE_HOVER;
         PH_LAND:     c = ST_CODE_LAND;
         PH_LANDED:   c = ST_CODE_LANDED;
         default:     c = ST_CODE_DISARMED;
      endcase
      return c;
   endfunction

endpackage

// File: sv/fms_csr.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor configuration registers
// Clamps each write into its legal range and holds the six settings.
// ----------------------------------------------------------------------------
module fms_csr
   import fms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [CT_W-1:0]        ct_raw;
   logic [CR_W-1:0]        cr_raw;
   logic signed [DR_W-1:0] dr_raw;
   logic [TD_W-1:0]        td_raw;
   logic [TIMER_W-1:0]     time_clamped;

   // Slice the write data to each register's width
   assign ct_raw = csr_data[CT_W-1:0];
   assign cr_raw = csr_data[CR_W-1:0];
   assign dr_raw = signed'(csr_data[DR_W-1:0]);
   assign td_raw = csr_data[TD_W-1:0];
   assign time_clamped = (csr_data > TIME_MAX) ? TIME_MAX : csr_data;

   // Clamp and steer the write to its register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CLIMB_TARGET: begin
               if (ct_raw < CT_MIN) cfg_in.climb_target = CT_MIN;
               else if (ct_raw > CT_MAX) cfg_in.climb_target = CT_MAX;
               else cfg_in.climb_target = ct_raw;
            end
            REG_ASCENT_SPEED: begin
               if (cr_raw < CR_MIN) cfg_in.ascent_speed = CR_MIN;
               else if (cr_raw > CR_MAX) cfg_in.ascent_speed = CR_MAX;
               else cfg_in.ascent_speed = cr_raw;
            end
            REG_SETTLE_TIME: begin
               cfg_in.settle_time = time_clamped;
            end
            REG_SINK_SPEED: begin
               if (dr_raw < DR_MIN) cfg_in.sink_speed = DR_MIN;
               else if (dr_raw > DR_MAX) cfg_in.sink_speed = DR_MAX;
               else cfg_in.sink_speed = dr_raw;
            end
            REG_TOUCHDOWN: begin
               if (td_raw < TD_MIN) cfg_in.touchdown_alt = TD_MIN;
               else if (td_raw > TD_MAX) cfg_in.touchdown_alt = TD_MAX;
               else cfg_in.touchdown_alt = td_raw;
            end
            REG_DISARM_DELAY: begin
               cfg_in.disarm_delay = time_clamped;
            end
            default: begin
               // drop writes beyond the register list
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/fms_core.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor core
// Input register, phase and timer update, and the result register.
// ----------------------------------------------------------------------------
module fms_core
   import fms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [MODE_W-1:0]          in_mode,
   input  logic signed [ALT_W-1:0]    in_alt,
   input  logic signed [VEL_IN_W-1:0] in_vel,
   input  logic [DT_W-1:0]            in_dt,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rsp_type                    out_rsp
);

   // Input stage
   logic                       s1_valid_ff;
   logic [MODE_W-1:0]          s1_mode_ff;
   logic signed [ALT_W-1:0]    s1_alt_ff;
   logic signed [VEL_IN_W-1:0] s1_vel_ff;
   logic [DT_W-1:0]            s1_dt_ff;

   // Supervisor state
   phase_type                  phase_ff, phase_in;
   logic [TIMER_W-1:0]         settle_ff, settle_in;
   logic [TIMER_W-1:0]         ground_ff, ground_in;
   logic signed [ALT_W-1:0]    alt_goal_ff, alt_goal_in;
   logic signed [VG_W-1:0]     vel_goal_ff, vel_goal_in;

   // Result stage
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff, rsp_in;

   logic                       advance;
   logic                       ok;
   logic [TIMER_W:0]           settle_sum, ground_sum;
   logic [TIMER_W-1:0]         settle_sat, ground_sat;
   logic signed [ALT_W:0]      alt_err;
   logic                       near_target;
   logic [TD_W:0]              low_limit;
   logic                       low_slow;

   // Move the held item into the result register when that slot frees up
   assign advance  = s1_valid_ff && (!rsp_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || advance;

   // Saturating timer sums
   assign settle_sum = {1'b0, settle_ff} + {{(TIMER_W + 1 - DT_W){1'b0}}, s1_dt_ff};
   assign ground_sum = {1'b0, ground_ff} + {{(TIMER_W + 1 - DT_W){1'b0}}, s1_dt_ff};
   assign settle_sat = settle_sum[TIMER_W] ? '1 : settle_sum[TIMER_W-1:0];
   assign ground_sat = ground_sum[TIMER_W] ? '1 : ground_sum[TIMER_W-1:0];

   // Altitude error against the climb target
   assign alt_err = signed'({{(ALT_W + 1 - CT_W){1'b0}}, cfg.climb_target})
                    - {s1_alt_ff[ALT_W-1], s1_alt_ff};
   assign near_target = (alt_err < SETTLE_WINDOW) && (alt_err > -SETTLE_WINDOW);

   // Low and slow test for touchdown
   assign low_limit = {1'b0, cfg.touchdown_alt} + LOW_MARGIN;
   assign low_slow  = (s1_alt_ff <= signed'({{(ALT_W - TD_W - 1){1'b0}}, low_limit}))
                      && (s1_vel_ff > -SLOW_WINDOW) && (s1_vel_ff < SLOW_WINDOW);

   // Next phase, timers and goals for the held item
   always_comb begin
      phase_in    = phase_ff;
      settle_in   = settle_ff;
      ground_in   = ground_ff;
      alt_goal_in = alt_goal_ff;
      vel_goal_in = vel_goal_ff;
      ok          = 1'b0;
      unique case (s1_mode_ff)
         MODE_TICK: begin
            ok = 1'b1;
            unique case (phase_ff)
               PH_DISARMED, PH_ARMED: begin
                  alt_goal_in = s1_alt_ff;
                  vel_goal_in = '0;
               end
               PH_TAKEOFF: begin
                  alt_goal_in = signed'({{(ALT_W - CT_W){1'b0}}, cfg.climb_target});
                  vel_goal_in = signed'({{(VG_W - CR_W){1'b0}}, cfg.ascent_speed});
                  if (near_target) begin
                     if (settle_sat >= cfg.settle_time) begin
                        phase_in  = PH_HOVER;
                        settle_in = '0;
                     end else begin
                        settle_in = settle_sat;
                     end
                  end else begin
                     settle_in = '0;
                  end
               end
               PH_HOVER: begin
                  vel_goal_in = '0;
               end
               PH_LAND: begin
                  alt_goal_in = signed'({{(ALT_W - TD_W){1'b0}}, cfg.touchdown_alt});
                  vel_goal_in = cfg.sink_speed;
                  if (low_slow) begin
                     if (ground_sat >= cfg.disarm_delay) begin
                        phase_in    = PH_LANDED;
                        ground_in   = '0;
                        alt_goal_in = '0;
                        vel_goal_in = '0;
                     end else begin
                        ground_in = ground_sat;
                     end
                  end else begin
                     ground_in = '0;
                  end
               end
               default: begin
                  alt_goal_in = '0;
                  vel_goal_in = '0;
               end
            endcase
         end
         MODE_ARM: begin
            if (phase_ff == PH_DISARMED) begin
               phase_in = PH_ARMED;
               ok       = 1'b1;
            end
         end
         MODE_DISARM: begin
            if (phase_ff == PH_ARMED || phase_ff == PH_LANDED) begin
               phase_in = PH_DISARMED;
               ok       = 1'b1;
            end
         end
         MODE_TAKEOFF: begin
            if (phase_ff == PH_ARMED || phase_ff == PH_LANDED) begin
               phase_in  = PH_TAKEOFF;
               settle_in = '0;
               ok        = 1'b1;
            end
         end
         MODE_LAND: begin
            if (phase_ff == PH_TAKEOFF || phase_ff == PH_HOVER || phase_ff == PH_ARMED) begin
               phase_in  = PH_LAND;
               ground_in = '0;
               ok        = 1'b1;
            end
         end
         MODE_HOVER: begin
            if (phase_ff == PH_TAKEOFF || phase_ff == PH_ARMED) begin
               phase_in = PH_HOVER;
               ok       = 1'b1;
            end
         end
         default: begin
            // unknown codes are rejected requests
            ok = 1'b0;
         end
      endcase
   end

   // Assemble the result item
   always_comb begin
      rsp_in.accepted      = ok;
      rsp_in.flight_state  = phase_code(phase_in);
      rsp_in.altitude_goal = alt_goal_in;
      rsp_in.velocity_goal = vel_goal_in;
      rsp_in.hold_active   = (phase_in == PH_TAKEOFF) || (phase_in == PH_HOVER)
                             || (phase_in == PH_LAND);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_DISARMED;
         settle_ff    <= '0;
         ground_ff    <= '0;
         alt_goal_ff  <= '0;
         vel_goal_ff  <= '0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            settle_ff    <= settle_in;
            ground_ff    <= ground_in;
            alt_goal_ff  <= alt_goal_in;
            vel_goal_ff  <= vel_goal_in;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_mode_ff <= in_mode;
         s1_alt_ff  <= in_alt;
         s1_vel_ff  <= in_vel;
         s1_dt_ff   <= in_dt;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: sv/flight_mode_supervisor.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor
// Six-phase arm/takeoff/hover/land sequencer driven by requests and ticks.
// ----------------------------------------------------------------------------
// Every request or tick on the req_ channel gives exactly one result on the
// rsp_ channel, after it has passed the input register and the result register.
// A new item is taken every cycle: one input register, a single pass of
// compare/add logic that updates the phase, the two saturating timers and
// the goals, and one result register; req_tready falls only while both
// registers are full and rsp_tready is low. The phase state is updated as
// the item moves into the result register, so consecutive items see each
// other's effect with no bubble. Settings are written through csr_ and are
// clamped to their legal ranges; write them only while no item is in flight.
module flight_mode_supervisor
   import fms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Requests and ticks
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // altitude_mm, velocity_mm_s, elapsed_ms
   input  logic [MODE_W-1:0]      req_tuser,  // mode
   // Results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // accepted, flight_state, altitude_goal_mm,
                                              // velocity_goal_mm_s, hold_active
   // Configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   rsp_type rsp;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   fms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fms_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_alt    (signed'(req_tdata[ALT_W-1:0])),
      .in_vel    (signed'(req_tdata[ALT_W+VEL_IN_W-1:ALT_W])),
      .in_dt     (req_tdata[ALT_W+VEL_IN_W+DT_W-1:ALT_W+VEL_IN_W]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   // Pack the result, padded to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_W){1'b0}}, rsp};

endmodule

// File: sv/fms_checker.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor port checker
// Watches the top-level ports for reset, stall and result consistency.
// ----------------------------------------------------------------------------
`include "flight_mode_supervisor_defines.svh"

module fms_checker
   import fms_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_type r;
   logic    in_hold_phase;

   // Unpack the result beat
   assign r = rsp_type'(rsp_tdata[RSP_W-1:0]);
   assign in_hold_phase = (r.flight_state == ST_CODE_TAKEOFF)
                          || (r.flight_state == ST_CODE_HOVER)
                          || (r.flight_state == ST_CODE_LAND);

   `FMS_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_tvalid,
                           "result valid after reset")

   `FMS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")

   `FMS_ASSERT_HOLDS(a_hold_flag, clock, reset, rsp_tvalid,
                     r.hold_active == in_hold_phase, "hold flag disagrees with phase")

   `FMS_ASSERT_HOLDS(a_landed_goals, clock, reset,
                     rsp_tvalid && (r.flight_state == ST_CODE_LANDED),
                     (r.altitude_goal == '0) && (r.velocity_goal == '0),
                     "landed with nonzero goals")

endmodule

bind flight_mode_supervisor fms_checker u_fms_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Flight mode supervisor testbench
// Drives requests and ticks on req_, settings on csr_, and checks every
// status beat on rsp_ against a cycle-free model of the supervisor kept here.
// Runs a directed flight, the setting extremes, then random flights under
// several random settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import fms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_PCT  = 17;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned MAX_REPORT = 10;
   localparam int unsigned TIMER_CAP  = 65535;

   // Mode and register codes that the block has no use for
   localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // altitude_mm, velocity_mm_s, elapsed_ms
   logic [MODE_W-1:0]      req_tuser = '0;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // accepted, flight_state, altitude_goal_mm,
                                       // velocity_goal_mm_s, hold_active
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Supervisor model: settings, phase, timers and goals
   int                 tgt_alt     = int'(CT_RESET);
   int                 climb_vel   = int'(CR_RESET);
   int                 settle_need = int'(TIME_RESET);
   int                 sink_vel    = int'(DR_RESET);
   int                 touch_alt   = int'(TD_RESET);
   int                 ground_need = int'(TIME_RESET);
   logic [STATE_W-1:0] flight      = ST_CODE_DISARMED;
   int                 settle_ms   = 0;
   int                 ground_ms   = 0;
   int                 goal_alt    = 0;
   int                 goal_vel    = 0;

   rsp_type status_due[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      no_gaps = 1'b0;

   flight_mode_supervisor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int add_sat(input int a, input int b);
      return (a + b > TIMER_CAP) ? TIMER_CAP : a + b;
   endfunction

   // Store one setting, masked to its width and clamped to its range
   function automatic void store_setting(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] value);
      int sv;
      sv = int'($signed(value[DR_W-1:0]));
      case (idx)
         REG_CLIMB_TARGET: tgt_alt     = clip(int'(value[CT_W-1:0]), int'(CT_MIN),
                                              int'(CT_MAX));
         REG_ASCENT_SPEED: climb_vel   = clip(int'(value[CR_W-1:0]), int'(CR_MIN),
                                              int'(CR_MAX));
         REG_SETTLE_TIME:  settle_need = clip(int'(value), 0, int'(TIME_MAX));
         REG_SINK_SPEED:   sink_vel    = clip(sv, int'(DR_MIN), int'(DR_MAX));
         REG_TOUCHDOWN:    touch_alt   = clip(int'(value[TD_W-1:0]), int'(TD_MIN),
                                              int'(TD_MAX));
         REG_DISARM_DELAY: ground_need = clip(int'(value), 0, int'(TIME_MAX));
         default: ;
      endcase
   endfunction

   // Apply one item to the model and return the status it reports
   function automatic rsp_type supervise(input logic [MODE_W-1:0] mode, input int alt,
                                         input int vel, input int dt);
      rsp_type r;
      bit      ok;
      int      err;
      ok = 1'b0;
      case (mode)
         MODE_TICK: begin
            ok = 1'b1;
            case (flight)
               ST_CODE_DISARMED, ST_CODE_ARMED: begin
                  goal_alt = alt;
                  goal_vel = 0;
               end
               ST_CODE_TAKEOFF: begin
                  goal_alt = tgt_alt;
                  goal_vel = climb_vel;
                  err = tgt_alt - alt;
                  if (err < 200 && err > -200) begin
                     settle_ms = add_sat(settle_ms, dt);
                     if (settle_ms >= settle_need) begin
                        flight = ST_CODE_HOVER;
                        settle_ms = 0;
                     end
                  end else begin
                     settle_ms = 0;
                  end
               end
               ST_CODE_HOVER: goal_vel = 0;
               ST_CODE_LAND: begin
                  goal_alt = touch_alt;
                  goal_vel = sink_vel;
                  if (alt <= touch_alt + 100 && vel > -200 && vel < 200) begin
                     ground_ms = add_sat(ground_ms, dt);
                     if (ground_ms >= ground_need) begin
                        flight = ST_CODE_LANDED;
                        ground_ms = 0;
                        goal_alt = 0;
                        goal_vel = 0;
                     end
                  end else begin
                     ground_ms = 0;
                  end
               end
               default: begin
                  goal_alt = 0;
                  goal_vel = 0;
               end
            endcase
         end
         MODE_ARM: if (flight == ST_CODE_DISARMED) begin
            flight = ST_CODE_ARMED;
            ok = 1'b1;
         end
         MODE_DISARM: if (flight == ST_CODE_ARMED || flight == ST_CODE_LANDED) begin
            flight = ST_CODE_DISARMED;
            ok = 1'b1;
         end
         MODE_TAKEOFF: if (flight == ST_CODE_ARMED || flight == ST_CODE_LANDED) begin
            flight = ST_CODE_TAKEOFF;
            settle_ms = 0;
            ok = 1'b1;
         end
         MODE_LAND: if (flight == ST_CODE_TAKEOFF || flight == ST_CODE_HOVER ||
                        flight == ST_CODE_ARMED) begin
            flight = ST_CODE_LAND;
            ground_ms = 0;
            ok = 1'b1;
         end
         MODE_HOVER: if (flight == ST_CODE_TAKEOFF || flight == ST_CODE_ARMED) begin
            flight = ST_CODE_HOVER;
            ok = 1'b1;
         end
         default: ;
      endcase
      r.accepted      = ok;
      r.flight_state  = flight;
      r.altitude_goal = goal_alt[ALT_W-1:0];
      r.velocity_goal = goal_vel[VG_W-1:0];
      r.hold_active   = (flight == ST_CODE_TAKEOFF || flight == ST_CODE_HOVER ||
                         flight == ST_CODE_LAND);
      return r;
   endfunction

   // Send one beat on req_; called and returns at a falling edge
   task automatic send_item(input logic [MODE_W-1:0] mode, input int alt,
                            input int vel, input int dt);
      int a;
      int v;
      a = int'($signed(alt[ALT_W-1:0]));
      v = int'($signed(vel[VEL_IN_W-1:0]));
      while (!no_gaps && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, dt[DT_W-1:0], vel[VEL_IN_W-1:0], alt[ALT_W-1:0]};
      do @(posedge clock); while (!req_tready);
      status_due.push_back(supervise(mode, a, v, int'(dt[DT_W-1:0])));
      @(negedge clock);
   endtask

   task automatic send_tick(input int alt, input int vel, input int dt);
      send_item(MODE_TICK, alt, vel, dt);
   endtask

   // Drop valid and wait until every status beat is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      store_setting(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly in range, sometimes any 16-bit value
   function automatic logic [CSR_DATA_W-1:0] draw_setting(input int lo, input int hi);
      int v;
      if ($urandom_range(3) != 0) v = lo + $urandom_range(hi - lo);
      else v = $urandom;
      return v[CSR_DATA_W-1:0];
   endfunction

   // Directed flight at reset settings through every request and window edge
   task automatic test_directed_flight();
      send_tick(131071, -32768, 1023);
      send_tick(-131072, 32767, 0);
      send_item(MODE_DISARM, 0, 0, 0);
      send_item(MODE_SPARE_LO, -1, -1, 1023);
      send_item(MODE_SPARE_HI, 0, 0, 0);
      send_item(MODE_ARM, 0, 0, 0);
      send_item(MODE_ARM, 0, 0, 0);
      send_item(MODE_LAND, 0, 0, 0);
      send_tick(400, -199, 1000);
      send_tick(401, 0, 1000);
      send_tick(400, 199, 1023);
      send_tick(0, -200, 500);
      send_tick(0, 0, 1023);
      send_tick(0, 0, 1000);
      send_item(MODE_TAKEOFF, 0, 0, 0);
      send_tick(1800, 0, 1000);
      send_tick(1801, 0, 1023);
      send_tick(2199, 0, 1000);
      send_item(MODE_TAKEOFF, 0, 0, 0);
      send_item(MODE_HOVER, 0, 0, 0);
      send_tick(5000, 300, 100);
      send_item(MODE_LAND, 0, 0, 0);
      send_tick(100, 200, 1023);
      send_item(MODE_ARM, 0, 0, 0);
      send_tick(100, 0, 1023);
      send_tick(100, 0, 1023);
      send_item(MODE_DISARM, 0, 0, 0);
      wait_idle();
   endtask

   // Fly once: arm, climb at target until hover, land low and slow, disarm
   task automatic fly_at_target(input int dt);
      send_item(MODE_ARM, 0, 0, 0);
      send_item(MODE_TAKEOFF, 0, 0, 0);
      while (flight == ST_CODE_TAKEOFF) send_tick(tgt_alt, 0, dt);
      send_item(MODE_LAND, 0, 0, 0);
      while (flight == ST_CODE_LAND) send_tick(touch_alt + 100, 0, dt);
      send_tick(touch_alt, 0, dt);
      send_item(MODE_DISARM, 0, 0, 0);
      wait_idle();
   endtask

   // Every register at and beyond both ends, plus the spare indexes
   task automatic test_setting_extremes();
      write_setting(REG_CLIMB_TARGET, 16'd0);
      write_setting(REG_ASCENT_SPEED, 16'd0);
      write_setting(REG_SETTLE_TIME, 16'd0);
      write_setting(REG_SINK_SPEED, 16'h0400);
      write_setting(REG_TOUCHDOWN, 16'd0);
      write_setting(REG_DISARM_DELAY, 16'd0);
      write_setting(REG_SPARE_LO, 16'hFFFF);
      write_setting(REG_SPARE_HI, 16'h5A5A);
      fly_at_target(0);
      write_setting(REG_CLIMB_TARGET, 16'hFFFF);
      write_setting(REG_ASCENT_SPEED, 16'hFFFF);
      write_setting(REG_SETTLE_TIME, 16'hFFFF);
      write_setting(REG_SINK_SPEED, 16'hFFFF);
      write_setting(REG_TOUCHDOWN, 16'hFFFF);
      write_setting(REG_DISARM_DELAY, 16'hFFFF);
      fly_at_target(1023);
      write_setting(REG_SETTLE_TIME, TIME_MAX);
      write_setting(REG_DISARM_DELAY, 16'd1);
      fly_at_target(1000);
   endtask

   // One item picked from the current phase, with some noise mixed in
   task automatic flight_step();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         send_item(MODE_W'($urandom_range(7)), $urandom, $urandom, $urandom);
      end else begin
         r = $urandom_range(99);
         case (flight)
            ST_CODE_DISARMED:
               if (r < 70) send_item(MODE_ARM, 0, 0, 0);
               else send_tick($urandom, $urandom, $urandom);
            ST_CODE_ARMED:
               if (r < 55) send_item(MODE_TAKEOFF, 0, 0, 0);
               else if (r < 65) send_item(MODE_HOVER, 0, 0, 0);
               else if (r < 75) send_item(MODE_LAND, 0, 0, 0);
               else if (r < 85) send_item(MODE_DISARM, 0, 0, 0);
               else send_tick($urandom, $urandom, $urandom);
            ST_CODE_TAKEOFF:
               if (r < 85) send_tick(tgt_alt + $urandom_range(500) - 250,
                                     $urandom_range(1000) - 500, $urandom_range(1023));
               else if (r < 92) send_tick($urandom, $urandom, $urandom);
               else if (r < 96) send_item(MODE_HOVER, 0, 0, 0);
               else send_item(MODE_LAND, 0, 0, 0);
            ST_CODE_HOVER:
               if (r < 70) send_tick($urandom, $urandom, $urandom);
               else if (r < 90) send_item(MODE_LAND, 0, 0, 0);
               else send_item(MODE_W'($urandom_range(7)), 0, 0, 0);
            ST_CODE_LAND:
               if (r < 85) send_tick(touch_alt + 150 - $urandom_range(400),
                                     $urandom_range(500) - 250, $urandom_range(1023));
               else if (r < 93) send_tick($urandom, $urandom, $urandom);
               else send_item(MODE_W'($urandom_range(7)), 0, 0, 0);
            default:
               if (r < 40) send_item(MODE_DISARM, 0, 0, 0);
               else if (r < 75) send_item(MODE_TAKEOFF, 0, 0, 0);
               else send_tick($urandom, $urandom, $urandom);
         endcase
      end
   endtask

   // Random flights under several random settings
   task automatic test_random_flights();
      for (int k = 0; k < 6; k++) begin
         write_setting(REG_CLIMB_TARGET, draw_setting(int'(CT_MIN), int'(CT_MAX)));
         write_setting(REG_ASCENT_SPEED, draw_setting(int'(CR_MIN), int'(CR_MAX)));
         write_setting(REG_SETTLE_TIME, draw_setting(0, 3000));
         write_setting(REG_SINK_SPEED, draw_setting(int'(DR_MIN), int'(DR_MAX)));
         write_setting(REG_TOUCHDOWN, draw_setting(int'(TD_MIN), int'(TD_MAX)));
         write_setting(REG_DISARM_DELAY, draw_setting(0, 3000));
         if ($urandom_range(1)) write_setting(REG_SPARE_HI, CSR_DATA_W'($urandom));
         no_gaps = (k == 2);
         repeat (121) flight_step();
         wait_idle();
         no_gaps = 1'b0;
      end
   endtask

   // Random output stalls
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
   end

   // Compare each status beat with the oldest one due
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_W-1:0];
         if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("unexpected status beat: %h", got);
         end else begin
            want = status_due.pop_front();
            if (got.accepted !== want.accepted || got.flight_state !== want.flight_state ||
                got.altitude_goal !== want.altitude_goal ||
                got.velocity_goal !== want.velocity_goal ||
                got.hold_active !== want.hold_active) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("status mismatch: exp acc %b st %0d alt %0d vel %0d hold %b, ",
                           want.accepted, want.flight_state, want.altitude_goal,
                           want.velocity_goal, want.hold_active,
                           "got acc %b st %0d alt %0d vel %0d hold %b",
                           got.accepted, got.flight_state, got.altitude_goal,
                           got.velocity_goal, got.hold_active);
            end
         end
      end
   end

   // Stop a hung run: count cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_flight();
      test_setting_extremes();
      test_random_flights();
      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: flight_mode_supervisor.f
+incdir+sv
sv/fms_pkg.sv
sv/fms_csr.sv
sv/fms_core.sv
sv/flight_mode_supervisor.sv
sv/fms_checker.sv
tb/tb_top.sv
